/* rtl/pgtm_pkg.sv */
package pgtm_pkg;

  localparam int unsigned TABLE_PAGES_DEF = 64;

  localparam int unsigned IDX_W     = 9;
  localparam int unsigned OFFS_W    = 12;
  localparam int unsigned VA_W      = 64;
  localparam int unsigned PA_W      = 64;
  localparam int unsigned FLAGS_W   = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned BASE_W    = 52;
  localparam int unsigned PFN_W     = BASE_W - OFFS_W;
  localparam int unsigned REL_W     = 52;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOTSUP = 3'd1,
    ST_INVAL  = 3'd2,
    ST_NOENT  = 3'd3,
    ST_BUSY   = 3'd4,
    ST_NOMEM  = 3'd5
  } status_e;

  // stored table entry; of the bits the block never sets, only huge is kept
  typedef struct packed {
    logic [PFN_W-1:0] addr;
    logic             huge;
    logic             user;
    logic             writable;
    logic             present;
  } entry_t;

  typedef struct packed {
    logic    latch;
    logic    rd;
    logic    wr_leaf;
    logic    sweep;
    logic    sweep_page;
    logic    sweep_init;
    logic    link;
    logic    desc_fast;
    logic    mod_start;
    logic    desc_slow;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    status_e chk_status;
    op_e     op;
    logic    present;
    logic    huge;
    logic    leaf;
    logic    pool_full;
    logic    fast_ok;
    logic    mod_done;
    logic    sweep_last_all;
    logic    sweep_last_page;
    logic    out_free;
  } sts_t;

endpackage

/* rtl/pgtm_store.sv */
module pgtm_store import pgtm_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [$clog2(TABLE_PAGES)+IDX_W-1:0]   addr_i,
  input  entry_t                                 wdata_i,
  output entry_t                                 rdata_o
);

  localparam int unsigned DEPTH = TABLE_PAGES << IDX_W;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pgtm_pmod.sv */
module pgtm_pmod import pgtm_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [REL_W-1:0]               rel_i,
  output logic                           fast_ok_o,
  output logic [$clog2(TABLE_PAGES)-1:0] fast_page_o,
  output logic                           done_o,
  output logic [$clog2(TABLE_PAGES)-1:0] page_o
);

  localparam int unsigned PAGE_W  = $clog2(TABLE_PAGES);
  localparam int unsigned R_W     = PAGE_W + 1;
  localparam int unsigned LO1_W   = 26;
  localparam int unsigned Y1_W    = 39;
  localparam int unsigned LO2_W   = 20;
  localparam int unsigned Y2_W    = 32;
  localparam bit          IS_POW2 = ((TABLE_PAGES & (TABLE_PAGES - 1)) == 0);
  localparam logic [Y1_W-1:0] FOLD1   = Y1_W'((64'd1 << LO1_W) % TABLE_PAGES);
  localparam logic [Y2_W-1:0] FOLD2   = Y2_W'((64'd1 << LO2_W) % TABLE_PAGES);
  localparam logic [Y2_W-1:0] RECIP   = Y2_W'((64'd1 << Y2_W) / TABLE_PAGES);
  localparam logic [R_W-1:0]  MODULUS = R_W'(TABLE_PAGES);

  logic [3:0]        stg_q, stg_d;
  logic [REL_W-1:0]  x_q;
  logic [Y1_W-1:0]   y1_q, y1_d;
  logic [Y2_W-1:0]   y2_q, y2_d;
  logic [2*Y2_W-1:0] prod;
  logic [Y2_W-1:0]   quot_q;
  logic [R_W-1:0]    low_q;
  logic [R_W-1:0]    qm;
  logic [R_W-1:0]    rem;
  logic [R_W-1:0]    reduced;

  // page numbers inside the pool, or any page number with a power-of-two pool, need no reduction
  assign fast_ok_o   = IS_POW2 || (rel_i < REL_W'(TABLE_PAGES));
  assign fast_page_o = rel_i[PAGE_W-1:0];

  // fold the page number twice, using 2^26 and 2^20 taken modulo the pool size
  assign y1_d = Y1_W'(x_q[REL_W-1:LO1_W]) * FOLD1 + Y1_W'(x_q[LO1_W-1:0]);
  assign y2_d = Y2_W'(y1_q[Y1_W-1:LO2_W]) * FOLD2 + Y2_W'(y1_q[LO2_W-1:0]);

  // reciprocal quotient estimate leaves a remainder below twice the pool size
  assign prod    = {{Y2_W{1'b0}}, y2_q} * {{Y2_W{1'b0}}, RECIP};
  assign qm      = quot_q[R_W-1:0] * MODULUS;
  assign rem     = low_q - qm;
  assign reduced = (rem >= MODULUS) ? rem - MODULUS : rem;

  assign stg_d  = {stg_q[2:0], start_i};
  assign done_o = stg_q[3];
  assign page_o = reduced[PAGE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= rel_i;
    end
    y1_q   <= y1_d;
    y2_q   <= y2_d;
    quot_q <= prod[2*Y2_W-1:Y2_W];
    low_q  <= y2_q[R_W-1:0];
  end

endmodule

/* rtl/pgtm_datapath.sv */
module pgtm_datapath import pgtm_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_wdata_i,
  input  op_e                  in_op_i,
  input  logic [VA_W-1:0]      in_va_i,
  input  logic [PA_W-1:0]      in_pa_i,
  input  logic [FLAGS_W-1:0]   in_flags_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  res_status_o,
  output logic [BASE_W-1:0]    res_phys_o,
  output logic [1:0]           res_flags_o
);

  localparam int unsigned PAGE_W = $clog2(TABLE_PAGES);
  localparam int unsigned ADDR_W = PAGE_W + IDX_W;
  localparam int unsigned NFP_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned DEPTH  = TABLE_PAGES << IDX_W;
  localparam logic [1:0]  LEAF_LEVEL = 2'd3;

  logic                enabled_q;
  logic [BASE_W-1:0]   base_q;
  op_e                 op_q;
  logic [VA_W-1:0]     va_q;
  logic [PA_W-1:0]     pa_q;
  logic [FLAGS_W-1:0]  fl_q;
  logic [1:0]          level_q;
  logic [PAGE_W-1:0]   page_q;
  logic [NFP_W-1:0]    nfp_q;
  logic [ADDR_W-1:0]   sweep_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [BASE_W-1:0]   res_phys_q;
  logic [1:0]          res_flags_q;

  logic [IDX_W-1:0]    idx;
  logic [ADDR_W-1:0]   slot;
  logic [ADDR_W-1:0]   sweep_addr;
  entry_t              rd_ent;
  entry_t              link_ent;
  entry_t              leaf_ent;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  entry_t              mem_wdata;
  logic [BASE_W:0]     diff;
  logic [REL_W-1:0]    rel;
  logic                fast_ok;
  logic [PAGE_W-1:0]   fast_page;
  logic                mod_done;
  logic [PAGE_W-1:0]   mod_page;
  logic                canon;
  logic                va_ok;
  status_e             chk_status;
  logic                xlate_ok;

  always_comb begin
    case (level_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign slot = {page_q, idx};

  always_comb begin
    canon = (va_q[VA_W-1:48] == 16'h0000) || (va_q[VA_W-1:48] == 16'hffff);
    va_ok = (va_q[OFFS_W-1:0] == '0) && canon;
    case (op_q)
      OP_MAP: begin
        if (!enabled_q) begin
          chk_status = ST_NOTSUP;
        end else if (!va_ok || (pa_q[OFFS_W-1:0] != '0) || (fl_q[FLAGS_W-1:2] != '0)) begin
          chk_status = ST_INVAL;
        end else begin
          chk_status = ST_OK;
        end
      end
      OP_UNMAP: begin
        if (!enabled_q) begin
          chk_status = ST_NOTSUP;
        end else if (!va_ok) begin
          chk_status = ST_INVAL;
        end else begin
          chk_status = ST_OK;
        end
      end
      OP_XLATE: begin
        if (!enabled_q) begin
          chk_status = ST_NOTSUP;
        end else if (!canon) begin
          chk_status = ST_INVAL;
        end else begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_INVAL;
    endcase
  end

  // page number of a followed pointer, relative to the root, 52-bit wrap
  assign diff = {1'b0, rd_ent.addr, {OFFS_W{1'b0}}} - {1'b0, base_q};
  assign rel  = {{OFFS_W{diff[BASE_W]}}, diff[BASE_W-1:OFFS_W]};

  pgtm_pmod #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_pmod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mod_start),
    .rel_i       (rel),
    .fast_ok_o   (fast_ok),
    .fast_page_o (fast_page),
    .done_o      (mod_done),
    .page_o      (mod_page)
  );

  always_comb begin
    link_ent          = '0;
    link_ent.addr     = base_q[BASE_W-1:OFFS_W] + PFN_W'(nfp_q);
    link_ent.writable = 1'b1;
    link_ent.present  = 1'b1;
    leaf_ent          = '0;
    leaf_ent.addr     = pa_q[BASE_W-1:OFFS_W];
    leaf_ent.user     = fl_q[1];
    leaf_ent.writable = fl_q[0];
    leaf_ent.present  = 1'b1;
  end

  assign sweep_addr = cmd_i.sweep_page ? {nfp_q[PAGE_W-1:0], sweep_q[IDX_W-1:0]} : sweep_q;

  always_comb begin
    mem_we   = cmd_i.sweep || cmd_i.link || cmd_i.wr_leaf;
    mem_addr = cmd_i.sweep ? sweep_addr : slot;
    if (cmd_i.link) begin
      mem_wdata = link_ent;
    end else if (cmd_i.wr_leaf && (op_q == OP_MAP)) begin
      mem_wdata = leaf_ent;
    end else begin
      mem_wdata = '0;
    end
  end

  pgtm_store #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (cmd_i.rd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rd_ent)
  );

  always_comb begin
    sts_o.chk_status      = chk_status;
    sts_o.op              = op_q;
    sts_o.present         = rd_ent.present;
    sts_o.huge            = rd_ent.huge;
    sts_o.leaf            = (level_q == LEAF_LEVEL);
    sts_o.pool_full       = (nfp_q >= NFP_W'(TABLE_PAGES));
    sts_o.fast_ok         = fast_ok;
    sts_o.mod_done        = mod_done;
    sts_o.sweep_last_all  = (sweep_q == ADDR_W'(DEPTH - 1));
    sts_o.sweep_last_page = &sweep_q[IDX_W-1:0];
    sts_o.out_free        = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      base_q      <= '0;
      level_q     <= '0;
      page_q      <= '0;
      nfp_q       <= NFP_W'(1);
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLED:    enabled_q <= cfg_wdata_i[0];
          CFG_TABLE_BASE: base_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.latch) begin
        level_q <= '0;
        page_q  <= '0;
      end else if (cmd_i.desc_fast) begin
        level_q <= level_q + 1'b1;
        page_q  <= fast_page;
      end else if (cmd_i.desc_slow) begin
        level_q <= level_q + 1'b1;
        page_q  <= mod_page;
      end
      if (cmd_i.link) begin
        nfp_q <= nfp_q + 1'b1;
      end
      if (cmd_i.sweep_init) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign xlate_ok = (cmd_i.out_status == ST_OK) && (op_q == OP_XLATE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= in_op_i;
      va_q <= in_va_i;
      pa_q <= in_pa_i;
      fl_q <= in_flags_i;
    end
    if (cmd_i.out_load) begin
      res_status_q <= cmd_i.out_status;
      res_phys_q   <= xlate_ok ? {rd_ent.addr, va_q[OFFS_W-1:0]} : '0;
      res_flags_q  <= xlate_ok ? {rd_ent.user, rd_ent.writable} : 2'b00;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_status_o = res_status_q;
  assign res_phys_o   = res_phys_q;
  assign res_flags_o  = res_flags_q;

endmodule

/* rtl/pgtm_ctrl.sv */
module pgtm_ctrl import pgtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_READ  = 9'b000010000,
    S_DESC  = 9'b000100000,
    S_SWEEP = 9'b001000000,
    S_LINK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    cmd_o            = '0;
    cmd_o.out_status = status_q;
    in_ready_o       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last_all) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.chk_status != ST_OK) begin
          status_d = sts_i.chk_status;
          state_d  = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts_i.leaf) begin
          if (!sts_i.present) begin
            if (sts_i.op != OP_MAP) begin
              status_d = ST_NOENT;
              state_d  = S_DONE;
            end else if (sts_i.pool_full) begin
              status_d = ST_NOMEM;
              state_d  = S_DONE;
            end else begin
              cmd_o.sweep_init = 1'b1;
              state_d          = S_SWEEP;
            end
          end else if (sts_i.huge) begin
            status_d = ST_BUSY;
            state_d  = S_DONE;
          end else if (sts_i.fast_ok) begin
            cmd_o.desc_fast = 1'b1;
            state_d         = S_READ;
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d         = S_DESC;
          end
        end else begin
          state_d = S_DONE;
          case (sts_i.op)
            OP_MAP: begin
              if (sts_i.present) begin
                status_d = ST_BUSY;
              end else begin
                cmd_o.wr_leaf = 1'b1;
                status_d      = ST_OK;
              end
            end
            OP_UNMAP: begin
              if (!sts_i.present) begin
                status_d = ST_NOENT;
              end else begin
                cmd_o.wr_leaf = 1'b1;
                status_d      = ST_OK;
              end
            end
            default: begin
              status_d = sts_i.present ? ST_OK : ST_NOENT;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_DESC: begin
        if (sts_i.mod_done) begin
          cmd_o.desc_slow = 1'b1;
          state_d         = S_READ;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_page = 1'b1;
        if (sts_i.sweep_last_page) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        // re-read the slot so the new link is walked like any other entry
        cmd_o.link = 1'b1;
        state_d    = S_READ;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

/* rtl/four_level_page_table_manager_top.sv */
// When a check fails, the result is loaded without any table read; a walk through existing
// tables does one table read and one evaluation per level.
// Only one item is in flight: a new item is accepted only after the last result is loaded.
// Each new intermediate table adds a clear of its 512 page entries, a link, a re-read and a
// re-eval; if the pool size is not a power of two, outside pointers are reduced modulo it.
// After reset the whole store is cleared with s_axis_tready low.
module four_level_page_table_manager_top import pgtm_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // virt_addr[63:0], phys_addr[127:64], map_flags[135:128]
  input  logic [135:0]         s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[2:0], phys_out[54:3], flags_out[56:55], zero[63:57]
  output logic [63:0]          m_axis_tdata
);

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] res_status;
  logic [BASE_W-1:0]   res_phys;
  logic [1:0]          res_flags;

  pgtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgtm_datapath #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (op_e'(s_axis_tuser)),
    .in_va_i      (s_axis_tdata[63:0]),
    .in_pa_i      (s_axis_tdata[127:64]),
    .in_flags_i   (s_axis_tdata[135:128]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_phys_o   (res_phys),
    .res_flags_o  (res_flags)
  );

  assign m_axis_tdata = {7'b0, res_flags, res_phys, res_status};

`ifndef SYNTHESIS
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd, cmd.wr_leaf, cmd.sweep, cmd.link}))
    else $error("more than one table store access in a cycle");

  a_link_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link |-> !sts.pool_full)
    else $error("table allocated from an exhausted pool");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrote an item not yet taken");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in flight");
`endif

endmodule
